@@ rtl/core/h264_rtp_depacketizer_assert.svh @@
// Assertion macros used by the depacketizer top level RTL.
`ifndef H264_RTP_DEPACKETIZER_ASSERT_SVH
`define H264_RTP_DEPACKETIZER_ASSERT_SVH

// Clocked check, muted while reset is high.
`define H264RTP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define H264RTP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/h264rtp_pkg.sv @@
// Types and constants shared by the H.264 RTP depacketizer.
`timescale 1ns / 1ps

package h264rtp_pkg;

  localparam logic [4:0] NAL_SLICE   = 5'd1;
  localparam logic [4:0] NAL_IDR     = 5'd5;
  localparam logic [4:0] NAL_SEI     = 5'd6;
  localparam logic [4:0] NAL_SPS     = 5'd7;
  localparam logic [4:0] NAL_PPS     = 5'd8;
  localparam logic [4:0] TYPE_STAP_A = 5'd24;
  localparam logic [4:0] TYPE_FU_A   = 5'd28;
  localparam logic [7:0] START_BIT   = 8'h80;
  localparam logic [7:0] SC_ZERO     = 8'h00;
  localparam logic [7:0] SC_ONE      = 8'h01;
  localparam logic [2:0] IDX_SC_ONE  = 3'd3;
  localparam logic [2:0] IDX_PAYLOAD = 3'd4;

  typedef enum logic [7:0] {
    MODE_AWAIT     = 8'b0000_0001,
    MODE_SINGLE    = 8'b0000_0010,
    MODE_DROP      = 8'b0000_0100,
    MODE_STAP_HI   = 8'b0000_1000,
    MODE_STAP_LO   = 8'b0001_0000,
    MODE_STAP_DATA = 8'b0010_0000,
    MODE_FU_HDR    = 8'b0100_0000,
    MODE_FU_DATA   = 8'b1000_0000
  } mode_t;

  // Output burst caused by one input item.
  typedef struct packed {
    logic       valid;     // item yields at least one output item
    logic       sc;        // burst opens with 00 00 00 01
    logic       has_byte;  // burst carries a payload byte
    logic [7:0] data;      // payload byte
  } burst_t;

endpackage

@@ rtl/core/h264rtp_parser.sv @@
// Payload parser: per-packet state and the burst each input item causes.
`timescale 1ns / 1ps

module h264rtp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output h264rtp_pkg::burst_t burst
);

  h264rtp_pkg::mode_t mode, mode_next;
  logic [15:0] nal_left, nal_left_next;
  logic [7:0]  len_hi, len_hi_next;
  logic [1:0]  nri, nri_next;
  logic [15:0] len_full;
  logic [4:0]  nal_type;

  assign nal_type = in_byte[4:0];
  assign len_full = {len_hi, in_byte};

  always_comb begin
    mode_next      = mode;
    nal_left_next  = nal_left;
    len_hi_next    = len_hi;
    nri_next       = nri;
    burst          = '0;
    burst.data     = in_byte;
    case (mode)
      h264rtp_pkg::MODE_AWAIT: begin
        if (nal_type inside {h264rtp_pkg::NAL_SLICE, h264rtp_pkg::NAL_IDR,
                             h264rtp_pkg::NAL_SEI, h264rtp_pkg::NAL_SPS,
                             h264rtp_pkg::NAL_PPS}) begin
          burst.valid    = 1'b1;
          burst.sc       = 1'b1;
          burst.has_byte = 1'b1;
          mode_next      = h264rtp_pkg::MODE_SINGLE;
        end else if (nal_type == h264rtp_pkg::TYPE_STAP_A) begin
          mode_next = h264rtp_pkg::MODE_STAP_HI;
        end else if (nal_type == h264rtp_pkg::TYPE_FU_A) begin
          nri_next  = in_byte[6:5];
          mode_next = h264rtp_pkg::MODE_FU_HDR;
        end else begin
          mode_next = h264rtp_pkg::MODE_DROP;
        end
      end
      h264rtp_pkg::MODE_SINGLE, h264rtp_pkg::MODE_FU_DATA: begin
        burst.valid    = 1'b1;
        burst.has_byte = 1'b1;
      end
      h264rtp_pkg::MODE_DROP: begin
      end
      h264rtp_pkg::MODE_STAP_HI: begin
        len_hi_next = in_byte;
        mode_next   = h264rtp_pkg::MODE_STAP_LO;
      end
      h264rtp_pkg::MODE_STAP_LO: begin
        nal_left_next = len_full;
        burst.valid   = 1'b1;
        burst.sc      = 1'b1;
        mode_next     = (len_full == 16'd0) ? h264rtp_pkg::MODE_STAP_HI
                                            : h264rtp_pkg::MODE_STAP_DATA;
      end
      h264rtp_pkg::MODE_STAP_DATA: begin
        burst.valid    = 1'b1;
        burst.has_byte = 1'b1;
        if (nal_left != 16'd0) begin
          nal_left_next = nal_left - 16'd1;
        end
        if (nal_left_next == 16'd0) begin
          mode_next = h264rtp_pkg::MODE_STAP_HI;
        end
      end
      h264rtp_pkg::MODE_FU_HDR: begin
        // rebuilt header: forbidden bit clear, NRI from indicator
        if ((in_byte & h264rtp_pkg::START_BIT) != 8'h00) begin
          burst.valid    = 1'b1;
          burst.sc       = 1'b1;
          burst.has_byte = 1'b1;
          burst.data     = {1'b0, nri, nal_type};
        end
        mode_next = h264rtp_pkg::MODE_FU_DATA;
      end
      default: begin
        mode_next = h264rtp_pkg::MODE_AWAIT;
      end
    endcase
    if (in_last) begin
      mode_next     = h264rtp_pkg::MODE_AWAIT;
      nal_left_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= h264rtp_pkg::MODE_AWAIT;
      nal_left <= 16'd0;
      len_hi   <= 8'd0;
      nri      <= 2'd0;
    end else if (accept) begin
      mode     <= mode_next;
      nal_left <= nal_left_next;
      len_hi   <= len_hi_next;
      nri      <= nri_next;
    end
  end

endmodule

@@ rtl/core/h264_rtp_depacketizer.sv @@
// Top level of the H.264 RTP depacketizer: input handshake and burst emitter.
`timescale 1ns / 1ps
// Usage:
//   Slave channel s_*: one RTP payload byte per item, s_tlast on the final
//   byte of each payload. Master channel m_*: one Annex B byte per item,
//   m_tuser on the first start code byte of a NAL unit, m_tlast on the last
//   output item caused by an input item.
// Output: the first output item of an input item appears in the cycle after
//   it is accepted.
// Throughput: the parser decides each item combinationally and loads a
//   burst register; the emitter drains it at one item per cycle while
//   m_tready is high. An input item causes 0, 1, 4 or 5 output items: one
//   for a pass-through byte, 4 or 5 for a byte that opens a NAL (start code
//   burst). s_tready is high when the burst register is empty or its final
//   item is taken in the same cycle, so one-byte results flow back to back.
// Reset (rst, synchronous): parser returns to waiting for the first byte of
//   a payload, length count cleared, burst register emptied.
// Stall: while m_tready is low the current output item holds and s_tready
//   drops; no byte is lost and parser state moves only on an accepted item.
`include "h264_rtp_depacketizer_assert.svh"

module h264_rtp_depacketizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // pkt_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // out_nal_begin
  output logic       m_tlast    // out_last
);

  h264rtp_pkg::burst_t burst_in;  // from parser
  h264rtp_pkg::burst_t burst;     // burst register
  logic [2:0] idx;                // position within burst
  logic       in_fire;
  logic       out_fire;
  logic       final_beat;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  h264rtp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_fire),
    .in_byte (s_tdata),
    .in_last (s_tlast),
    .burst   (burst_in)
  );

  // last beat: plain byte, 4th start code byte, or trailing payload byte
  always_comb begin
    if (!burst.sc) begin
      final_beat = 1'b1;
    end else if (burst.has_byte) begin
      final_beat = (idx == h264rtp_pkg::IDX_PAYLOAD);
    end else begin
      final_beat = (idx == h264rtp_pkg::IDX_SC_ONE);
    end
  end

  always_comb begin
    if (!burst.sc || idx == h264rtp_pkg::IDX_PAYLOAD) begin
      m_tdata = burst.data;
    end else if (idx == h264rtp_pkg::IDX_SC_ONE) begin
      m_tdata = h264rtp_pkg::SC_ONE;
    end else begin
      m_tdata = h264rtp_pkg::SC_ZERO;
    end
  end

  assign m_tvalid = burst.valid;
  assign m_tuser  = burst.sc && (idx == 3'd0);
  assign m_tlast  = final_beat;
  assign s_tready = !burst.valid || (m_tready && final_beat);

  // only the valid bit and index are reset; payload bits load with an item
  always_ff @(posedge clk) begin
    if (rst) begin
      burst.valid <= 1'b0;
      idx         <= 3'd0;
    end else if (in_fire && burst_in.valid) begin
      burst <= burst_in;
      idx   <= 3'd0;
    end else if (out_fire) begin
      if (final_beat) begin
        burst.valid <= 1'b0;
        idx         <= 3'd0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  `H264RTP_ASSERT(a_begin_is_zero, clk, rst,
    m_tvalid && m_tuser |-> m_tdata == 8'h00, "NAL begin not on a zero byte")
  `H264RTP_ASSERT(a_begin_not_last, clk, rst,
    m_tvalid && m_tuser |-> !m_tlast, "start code burst ended on first byte")
  `H264RTP_ASSERT(a_ready_when_free, clk, rst,
    s_tready && m_tvalid |-> m_tready && m_tlast, "input taken while burst still pending")
  `H264RTP_ASSERT(a_burst_continues, clk, rst,
    out_fire && !m_tlast |=> m_tvalid && idx == $past(idx) + 3'd1,
    "burst dropped before its last item")
  `H264RTP_ASSERT_ALWAYS(a_idx_range, clk,
    rst || idx <= h264rtp_pkg::IDX_PAYLOAD, "burst index out of range")

endmodule

@@ tb/h264_rtp_depacketizer_test.sv @@
// Self-checking testbench for the H.264 RTP depacketizer (directed and random packets).
`timescale 1ns / 1ps

module h264_rtp_depacketizer_test;

  // NAL unit types used only by the stimulus
  localparam logic [4:0] NAL_UNSPEC   = 5'd0;
  localparam logic [4:0] NAL_RESERVED = 5'd31;
  localparam logic [7:0] TYPE_MASK    = 8'h1f;
  localparam logic [7:0] NRI_MASK     = 8'h60;

  // One Annex B output byte as seen on the master side
  typedef struct packed {
    logic [7:0] data;
    logic       nal_begin;
    logic       last;
  } annexb_byte_t;

  // Tracks the parser state and holds the Annex B bytes still owed by the block
  class annexb_scoreboard;
    h264rtp_pkg::mode_t mode;
    logic [15:0]  nal_left;
    logic [7:0]   len_hi;
    logic [1:0]   nri;
    annexb_byte_t burst_q[$];
    annexb_byte_t expected_q[$];
    int           errors;

    function new();
      mode     = h264rtp_pkg::MODE_AWAIT;
      nal_left = '0;
      len_hi   = '0;
      nri      = '0;
      errors   = 0;
    endfunction

    function void add_byte(logic [7:0] data, logic nal_begin);
      burst_q.push_back('{data, nal_begin, 1'b0});
    endfunction

    function void add_start_code();
      add_byte(h264rtp_pkg::SC_ZERO, 1'b1);
      add_byte(h264rtp_pkg::SC_ZERO, 1'b0);
      add_byte(h264rtp_pkg::SC_ZERO, 1'b0);
      add_byte(h264rtp_pkg::SC_ONE, 1'b0);
    endfunction

    // Work out the output burst of one accepted payload byte
    function void note_input(logic [7:0] b, logic pkt_end);
      logic [4:0] nal_type;
      nal_type = 5'(b & TYPE_MASK);
      burst_q.delete();
      case (mode)
        h264rtp_pkg::MODE_AWAIT: begin
          if (nal_type inside {h264rtp_pkg::NAL_SLICE, h264rtp_pkg::NAL_IDR,
                               h264rtp_pkg::NAL_SEI, h264rtp_pkg::NAL_SPS,
                               h264rtp_pkg::NAL_PPS}) begin
            add_start_code();
            add_byte(b, 1'b0);
            mode = h264rtp_pkg::MODE_SINGLE;
          end else if (nal_type == h264rtp_pkg::TYPE_STAP_A) begin
            mode = h264rtp_pkg::MODE_STAP_HI;
          end else if (nal_type == h264rtp_pkg::TYPE_FU_A) begin
            nri  = 2'((b & NRI_MASK) >> 5);
            mode = h264rtp_pkg::MODE_FU_HDR;
          end else begin
            mode = h264rtp_pkg::MODE_DROP;
          end
        end
        h264rtp_pkg::MODE_SINGLE, h264rtp_pkg::MODE_FU_DATA: add_byte(b, 1'b0);
        h264rtp_pkg::MODE_DROP: ;
        h264rtp_pkg::MODE_STAP_HI: begin
          len_hi = b;
          mode   = h264rtp_pkg::MODE_STAP_LO;
        end
        h264rtp_pkg::MODE_STAP_LO: begin
          nal_left = {len_hi, b};
          add_start_code();
          mode = (nal_left == 16'd0) ? h264rtp_pkg::MODE_STAP_HI
                                     : h264rtp_pkg::MODE_STAP_DATA;
        end
        h264rtp_pkg::MODE_STAP_DATA: begin
          add_byte(b, 1'b0);
          if (nal_left != 16'd0) nal_left = nal_left - 16'd1;
          if (nal_left == 16'd0) mode = h264rtp_pkg::MODE_STAP_HI;
        end
        h264rtp_pkg::MODE_FU_HDR: begin
          // rebuilt header: forbidden bit clear, NRI from indicator, type from FU header
          if ((b & h264rtp_pkg::START_BIT) != 8'h00) begin
            add_start_code();
            add_byte({1'b0, nri, nal_type}, 1'b0);
          end
          mode = h264rtp_pkg::MODE_FU_DATA;
        end
        default: mode = h264rtp_pkg::MODE_AWAIT;
      endcase
      if (pkt_end) begin
        mode     = h264rtp_pkg::MODE_AWAIT;
        nal_left = '0;
      end
      if (burst_q.size() != 0) burst_q[burst_q.size() - 1].last = 1'b1;
      foreach (burst_q[i]) expected_q.push_back(burst_q[i]);
    endfunction

    function void check_result(logic [7:0] data, logic nal_begin, logic last);
      annexb_byte_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected output item: out_byte 0x%02h", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected 0x%02h, got 0x%02h", want.data, data);
        errors++;
      end
      if (nal_begin !== want.nal_begin) begin
        $error("out_nal_begin: expected %0b, got %0b", want.nal_begin, nal_begin);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
  logic       s_tlast = 1'b0;    // pkt_last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tuser;           // out_nal_begin
  logic       m_tlast;           // out_last

  annexb_scoreboard sb;
  logic [7:0] pkt[$];            // payload bytes of the packet being sent
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;        // cycles the sink still holds off
  int items_sent     = 0;

  h264_rtp_depacketizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  // Sink: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Monitor: note accepted payload bytes, check accepted output bytes
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  // Offer one item; returns at the edge that accepts it. s_tvalid stays high
  // so back-to-back items need no second assignment in the same step.
  task automatic send_item(input logic [7:0] b, input logic pkt_end);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= pkt_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_item(pkt[i], i == pkt.size() - 1);
  endtask

  // Sender stops until the sink has drained every owed byte
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] nal_header(logic [4:0] t);
    logic [7:0] h;
    h      = 8'($urandom);   // random forbidden and NRI bits
    h[4:0] = t;
    return h;
  endfunction

  function automatic void add_payload(int len);
    repeat (len) pkt.push_back(8'($urandom));
  endfunction

  // One random packet: mostly well-formed single NAL, STAP-A and FU-A,
  // the rest unknown types and noise
  task automatic random_packet();
    int form, len, cut;
    logic [4:0] t;
    pkt.delete();
    form = $urandom_range(99);
    if (form < 25) begin
      case ($urandom_range(4))
        0: t = h264rtp_pkg::NAL_SLICE;
        1: t = h264rtp_pkg::NAL_IDR;
        2: t = h264rtp_pkg::NAL_SEI;
        3: t = h264rtp_pkg::NAL_SPS;
        default: t = h264rtp_pkg::NAL_PPS;
      endcase
      pkt.push_back(nal_header(t));
      add_payload($urandom_range(8));
    end else if (form < 50) begin
      pkt.push_back(nal_header(h264rtp_pkg::TYPE_STAP_A));
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(5);
        pkt.push_back(8'h00);
        pkt.push_back(8'(len));
        add_payload(len);
      end
      case ($urandom_range(9))
        0, 1: begin
          // packet cut short anywhere
          cut = $urandom_range(1, pkt.size());
          pkt = pkt[0:cut-1];
        end
        2: add_payload(1);   // lone trailing byte
        3: begin
          // long length, packet ends before the NAL does
          pkt.push_back(8'($urandom_range(1, 255)));
          pkt.push_back(8'($urandom));
          add_payload($urandom_range(4));
        end
        default: ;
      endcase
    end else if (form < 75) begin
      pkt.push_back(nal_header(h264rtp_pkg::TYPE_FU_A));
      pkt.push_back(8'($urandom));   // FU header: start, end, type all random
      add_payload($urandom_range(8));
    end else if (form < 88) begin
      do begin
        t = 5'($urandom);
      end while (t inside {h264rtp_pkg::NAL_SLICE, h264rtp_pkg::NAL_IDR,
                           h264rtp_pkg::NAL_SEI, h264rtp_pkg::NAL_SPS,
                           h264rtp_pkg::NAL_PPS, h264rtp_pkg::TYPE_STAP_A,
                           h264rtp_pkg::TYPE_FU_A});
      pkt.push_back(nal_header(t));
      add_payload($urandom_range(6));
    end else begin
      add_payload($urandom_range(1, 6));
    end
    items_sent += pkt.size();
    send_packet();
  endtask

  task automatic directed_packets();
    // single NAL, forbidden bit set, data extremes
    pkt = '{{1'b1, 2'b11, h264rtp_pkg::NAL_SLICE}, 8'hff, 8'h00};
    send_packet();
    pkt = '{{1'b0, 2'b00, h264rtp_pkg::NAL_IDR}};
    send_packet();
    pkt = '{{1'b0, 2'b01, h264rtp_pkg::NAL_SEI}};
    send_packet();
    pkt = '{{1'b0, 2'b10, h264rtp_pkg::NAL_SPS}};
    send_packet();
    pkt = '{{1'b1, 2'b11, h264rtp_pkg::NAL_PPS}};
    send_packet();
    // STAP-A: zero length, a two-byte NAL, then a lone trailing byte
    pkt = '{{1'b0, 2'b11, h264rtp_pkg::TYPE_STAP_A}, 8'h00, 8'h00, 8'h00, 8'h02,
            8'haa, 8'hbb, 8'h7f};
    send_packet();
    // FU-A with start bit, then without start bit but with end bit
    pkt = '{{1'b0, 2'b10, h264rtp_pkg::TYPE_FU_A},
            {1'b1, 1'b0, 1'b0, h264rtp_pkg::NAL_IDR}, 8'h55};
    send_packet();
    pkt = '{{1'b1, 2'b01, h264rtp_pkg::TYPE_FU_A},
            {1'b0, 1'b1, 1'b0, h264rtp_pkg::NAL_IDR}, 8'hc3};
    send_packet();
    // unknown types are dropped
    pkt = '{{1'b0, 2'b00, NAL_UNSPEC}, 8'hff};
    send_packet();
    pkt = '{{1'b1, 2'b11, NAL_RESERVED}};
    send_packet();
    // STAP-A that ends inside its length field
    pkt = '{{1'b0, 2'b01, h264rtp_pkg::TYPE_STAP_A}, 8'h12};
    send_packet();
  endtask

  // Hard limit on run time
  initial begin
    #4ms;
    $display("** h264_rtp_depacketizer: FAILED **");
    $finish;
  end

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int tail;
    idle_tab  = '{0, 45, 0, 12};
    stall_tab = '{0, 0, 45, 12};
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = idle_tab[p];
      sink_stall_pct = stall_tab[p];
      if (p == 0) begin
        directed_packets();
        // long sink hold-off while the sender keeps offering
        hold_left = 80;
      end
      while (items_sent < (p + 1) * 100) random_packet();
      wait_drained();
    end

    tail = 0;
    while (sb.pending() != 0 && tail < 5000) begin
      @(posedge clk);
      tail++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected output items never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("** h264_rtp_depacketizer: PASSED **");
    end else begin
      $display("** h264_rtp_depacketizer: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/h264rtp_pkg.sv
rtl/core/h264rtp_parser.sv
rtl/core/h264_rtp_depacketizer.sv
tb/h264_rtp_depacketizer_test.sv
